>>> design/deq_pkg.sv
// ---------------------------------------------------------------------------
// deq_pkg - shared types and constants of the double-ended queue
// Operation and status codes, field widths, and the command and status
// structs that join the controller to the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    // Fixed field widths of the request and result channels
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Default sizing of the store
    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;

    // Operation requested by one item
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_REMOVE     = 3'd4,
        MODE_PEEK       = 3'd5
    } t_mode;

    // Result status
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    // Store address sources, all relative to the head slot
    typedef enum logic [2:0] {
        ADDR_HEAD  = 3'd0,  // front entry
        ADDR_TAIL  = 3'd1,  // first free slot behind the back
        ADDR_LAST  = 3'd2,  // back entry
        ADDR_IDX   = 3'd3,  // entry at the scan index
        ADDR_IDX1  = 3'd4,  // entry after the scan index
        ADDR_IDX2  = 3'd5,  // two entries after the scan index
        ADDR_FRONT = 3'd6   // free slot in front of the head
    } t_addr_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic      req_ready;
        logic      load_req;
        logic      wr_en;
        t_addr_sel wr_addr;
        logic      wr_from_mem;
        t_addr_sel rd_addr;
        logic      head_inc;
        logic      head_dec;
        logic      occ_inc;
        logic      occ_dec;
        logic      idx_clr;
        logic      idx_inc;
        logic      res_load;
        logic      st_load;
        t_status   st;
        logic      out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic  req_valid;
        t_mode mode;
        logic  empty;
        logic  full;
        logic  match;
        logic  scan_last;
        logic  shift_last;
        logic  out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> design/deq_req_if.sv
// ---------------------------------------------------------------------------
// deq_req_if - request channel of the double-ended queue
// Valid/ready handshake carrying the operation code and its data.
// ---------------------------------------------------------------------------
`default_nettype none

interface deq_req_if;
    logic                         valid;
    logic                         ready;
    logic [deq_pkg::MODE_W-1:0]   mode;
    logic [deq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

>>> design/deq_res_if.sv
// ---------------------------------------------------------------------------
// deq_res_if - result channel of the double-ended queue
// Valid/ready handshake carrying the returned entry, status and count.
// ---------------------------------------------------------------------------
`default_nettype none

interface deq_res_if;
    logic                          valid;
    logic                          ready;
    logic [deq_pkg::VALUE_W-1:0]   value_res;
    logic [deq_pkg::STATUS_W-1:0]  status;
    logic [deq_pkg::COUNT_W-1:0]   count;

    modport source (output valid, output value_res, output status, output count, input ready);
    modport sink   (input valid, input value_res, input status, input count, output ready);
endinterface

`default_nettype wire

>>> design/deque_with_remove_by_match.sv
// ---------------------------------------------------------------------------
// deque_with_remove_by_match - bounded double-ended queue
// Push and pop at both ends, peek at the front, and removal of the first
// entry equal to a given value with the gap closed in order.
// ---------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Payload
//  i_req     in   valid/ready    mode[2:0], value[31:0]
//  o_res     out  valid/ready    value_res[31:0], status[1:0], count[4:0]
//
//  One request is in work at a time; ready is high only between requests.
//  Pushes and unused codes pass decode and finish, pops and peek add one
//  store read. Removal compares entries from the front one a cycle until
//  the match, then moves the entries behind it down one a cycle.
//  A result waits in the output register; a stalled output holds the next
//  result in the finish step. Synchronous reset empties the queue.
//
`default_nettype none

module deque_with_remove_by_match #(
    parameter int DEPTH  = deq_pkg::DEPTH_DEF,
    parameter int DATA_W = deq_pkg::DATA_W_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    deq_req_if.sink   i_req,
    deq_res_if.source o_res
);

    deq_pkg::t_cmd  cmd;
    deq_pkg::t_stat stat;

    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    deq_dpath #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_res   (o_res),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

`default_nettype wire

>>> design/deq_ram.sv
// ---------------------------------------------------------------------------
// deq_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
    parameter int WIDTH = deq_pkg::DATA_W_DEF,
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write, and registered read of the addressed slot
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/deq_ctrl.sv
// ---------------------------------------------------------------------------
// deq_ctrl - controller of the double-ended queue
// Sequences each request: decode, store read, match scan, compaction
// and hand-off of the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire deq_pkg::t_stat i_stat,
    output deq_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    t_state        r_state;
    t_state        n_state;
    deq_pkg::t_cmd n_cmd;

    // Next state and commands
    always_comb begin
        n_state           = r_state;
        n_cmd.req_ready   = 1'b0;
        n_cmd.load_req    = 1'b0;
        n_cmd.wr_en       = 1'b0;
        n_cmd.wr_addr     = deq_pkg::ADDR_TAIL;
        n_cmd.wr_from_mem = 1'b0;
        n_cmd.rd_addr     = deq_pkg::ADDR_HEAD;
        n_cmd.head_inc    = 1'b0;
        n_cmd.head_dec    = 1'b0;
        n_cmd.occ_inc     = 1'b0;
        n_cmd.occ_dec     = 1'b0;
        n_cmd.idx_clr     = 1'b0;
        n_cmd.idx_inc     = 1'b0;
        n_cmd.res_load    = 1'b0;
        n_cmd.st_load     = 1'b0;
        n_cmd.st          = deq_pkg::ST_OK;
        n_cmd.out_load    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // Take a new request
                n_cmd.req_ready = 1'b1;
                if (i_stat.req_valid) begin
                    n_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_FINISH;
                unique case (i_stat.mode) inside
                    deq_pkg::MODE_PUSH_BACK: begin
                        if (i_stat.full) begin
                            n_cmd.st_load = 1'b1;
                            n_cmd.st      = deq_pkg::ST_FULL;
                        end else begin
                            n_cmd.wr_en   = 1'b1;
                            n_cmd.wr_addr = deq_pkg::ADDR_TAIL;
                            n_cmd.occ_inc = 1'b1;
                        end
                    end
                    deq_pkg::MODE_PUSH_FRONT: begin
                        if (i_stat.full) begin
                            n_cmd.st_load = 1'b1;
                            n_cmd.st      = deq_pkg::ST_FULL;
                        end else begin
                            n_cmd.wr_en    = 1'b1;
                            n_cmd.wr_addr  = deq_pkg::ADDR_FRONT;
                            n_cmd.head_dec = 1'b1;
                            n_cmd.occ_inc  = 1'b1;
                        end
                    end
                    deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_PEEK,
                    deq_pkg::MODE_POP_BACK: begin
                        if (i_stat.empty) begin
                            n_cmd.st_load = 1'b1;
                            n_cmd.st      = deq_pkg::ST_EMPTY;
                        end else begin
                            n_cmd.rd_addr = (i_stat.mode == deq_pkg::MODE_POP_BACK) ?
                                            deq_pkg::ADDR_LAST : deq_pkg::ADDR_HEAD;
                            n_state       = S_READ;
                        end
                    end
                    deq_pkg::MODE_REMOVE: begin
                        if (i_stat.empty) begin
                            n_cmd.st_load = 1'b1;
                            n_cmd.st      = deq_pkg::ST_EMPTY;
                        end else begin
                            // Start the scan at the front entry
                            n_cmd.idx_clr = 1'b1;
                            n_cmd.rd_addr = deq_pkg::ADDR_HEAD;
                            n_state       = S_SCAN;
                        end
                    end
                    default: begin
                        // Unused codes: report the count only
                    end
                endcase
            end

            S_READ: begin
                // Capture the entry and retire it for pops
                n_cmd.res_load = 1'b1;
                if (i_stat.mode == deq_pkg::MODE_POP_FRONT) begin
                    n_cmd.head_inc = 1'b1;
                    n_cmd.occ_dec  = 1'b1;
                end else if (i_stat.mode == deq_pkg::MODE_POP_BACK) begin
                    n_cmd.occ_dec = 1'b1;
                end
                n_state = S_FINISH;
            end

            S_SCAN: begin
                // Compare one entry a cycle while fetching the next
                n_cmd.rd_addr = deq_pkg::ADDR_IDX1;
                if (i_stat.match) begin
                    if (i_stat.scan_last) begin
                        n_cmd.occ_dec = 1'b1;
                        n_state       = S_FINISH;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (i_stat.scan_last) begin
                    n_cmd.st_load = 1'b1;
                    n_cmd.st      = deq_pkg::ST_NOMATCH;
                    n_state       = S_FINISH;
                end else begin
                    n_cmd.idx_inc = 1'b1;
                end
            end

            S_SHIFT: begin
                // Move the following entry down by one slot
                n_cmd.wr_en       = 1'b1;
                n_cmd.wr_addr     = deq_pkg::ADDR_IDX;
                n_cmd.wr_from_mem = 1'b1;
                n_cmd.idx_inc     = 1'b1;
                n_cmd.rd_addr     = deq_pkg::ADDR_IDX2;
                if (i_stat.shift_last) begin
                    n_cmd.occ_dec = 1'b1;
                    n_state       = S_FINISH;
                end
            end

            S_FINISH: begin
                // Hold until the output register is free
                if (i_stat.out_free) begin
                    n_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = n_cmd;

endmodule

`default_nettype wire

>>> design/deq_dpath.sv
// ---------------------------------------------------------------------------
// deq_dpath - datapath of the double-ended queue
// Entry store, head pointer, occupancy, scan index, match compare,
// and the result and output registers.
// ---------------------------------------------------------------------------
`default_nettype none

module deq_dpath #(
    parameter int DEPTH  = deq_pkg::DEPTH_DEF,
    parameter int DATA_W = deq_pkg::DATA_W_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    deq_req_if.sink             i_req,
    deq_res_if.source           o_res,
    input  wire deq_pkg::t_cmd  i_cmd,
    output deq_pkg::t_stat      o_stat
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OFF_W   = CNT_W + 1;
    localparam int SUM_W   = OFF_W + 1;
    localparam int VALUE_W = deq_pkg::VALUE_W;
    localparam int COUNT_W = deq_pkg::COUNT_W;
    localparam int EXT_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic [AW-1:0]        r_head;
    logic [CNT_W-1:0]     r_occ;
    logic [CNT_W-1:0]     r_idx;
    deq_pkg::t_mode       r_mode;
    logic [DATA_W-1:0]    r_key;
    logic [DATA_W-1:0]    r_res;
    deq_pkg::t_status     r_st;
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_value;
    deq_pkg::t_status     r_out_status;
    logic [COUNT_W-1:0]   r_out_count;

    logic [AW-1:0]        head_dec;
    logic [AW-1:0]        head_inc;
    logic [OFF_W-1:0]     off_occ;
    logic [OFF_W-1:0]     off_idx;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [DATA_W-1:0]    wr_data;
    logic [DATA_W-1:0]    rd_data;
    logic [EXT_W-1:0]     occ_ext;

    // Slot of the entry at a given distance from the head
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [OFF_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Resolve an address source to a store slot
    function automatic logic [AW-1:0] addr_of(input deq_pkg::t_addr_sel sel,
                                              input logic [AW-1:0] head,
                                              input logic [AW-1:0] hdec,
                                              input logic [OFF_W-1:0] occ,
                                              input logic [OFF_W-1:0] idx);
        logic [AW-1:0] a;
        case (sel)
            deq_pkg::ADDR_HEAD:  a = head;
            deq_pkg::ADDR_TAIL:  a = slot_of(head, occ);
            deq_pkg::ADDR_LAST:  a = slot_of(head, occ - OFF_W'(1));
            deq_pkg::ADDR_IDX:   a = slot_of(head, idx);
            deq_pkg::ADDR_IDX1:  a = slot_of(head, idx + OFF_W'(1));
            deq_pkg::ADDR_IDX2:  a = slot_of(head, idx + OFF_W'(2));
            deq_pkg::ADDR_FRONT: a = hdec;
            default:             a = head;
        endcase
        return a;
    endfunction

    // Pointer neighbors with wrap at the store depth
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign off_occ  = OFF_W'(r_occ);
    assign off_idx  = OFF_W'(r_idx);

    // Store addressing and write data
    assign wr_addr = addr_of(i_cmd.wr_addr, r_head, head_dec, off_occ, off_idx);
    assign rd_addr = addr_of(i_cmd.rd_addr, r_head, head_dec, off_occ, off_idx);
    assign wr_data = i_cmd.wr_from_mem ? rd_data : r_key;

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Status back to the controller
    assign o_stat.req_valid  = i_req.valid;
    assign o_stat.mode       = r_mode;
    assign o_stat.empty      = (r_occ == '0);
    assign o_stat.full       = (r_occ == CNT_W'(DEPTH));
    assign o_stat.match      = (rd_data == r_key);
    assign o_stat.scan_last  = ((off_idx + OFF_W'(1)) == off_occ);
    assign o_stat.shift_last = ((off_idx + OFF_W'(2)) == off_occ);
    assign o_stat.out_free   = !r_out_valid || o_res.ready;

    // Pointer, occupancy and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_occ  <= '0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.head_inc) begin
                r_head <= head_inc;
            end else if (i_cmd.head_dec) begin
                r_head <= head_dec;
            end
            if (i_cmd.occ_inc) begin
                r_occ <= r_occ + CNT_W'(1);
            end else if (i_cmd.occ_dec) begin
                r_occ <= r_occ - CNT_W'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    // Request capture and pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_mode <= deq_pkg::t_mode'(i_req.mode);
            r_key  <= DATA_W'(i_req.value);
            r_res  <= '0;
            r_st   <= deq_pkg::ST_OK;
        end else begin
            if (i_cmd.res_load) begin
                r_res <= rd_data;
            end
            if (i_cmd.st_load) begin
                r_st <= i_cmd.st;
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload, count taken after the update
    assign occ_ext = EXT_W'(r_occ);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= VALUE_W'(r_res);
            r_out_status <= r_st;
            r_out_count  <= occ_ext[COUNT_W-1:0];
        end
    end

    assign i_req.ready     = i_cmd.req_ready;
    assign o_res.valid     = r_out_valid;
    assign o_res.value_res = r_out_value;
    assign o_res.status    = r_out_status;
    assign o_res.count     = r_out_count;

endmodule

`default_nettype wire

>>> tb/sv/deq_result_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// deq_result_checker - result predictor and comparator for the deque
// Watches the request and result channels, keeps its own copy of the
// queue contents, predicts one result per accepted request and compares
// each accepted result field by field with the oldest prediction.
// ---------------------------------------------------------------------------

module deq_result_checker
    import deq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    deq_req_if   i_req,
    deq_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int DEPTH      = DEPTH_DEF;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] value_res;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_deq_result;

    // Shadow of the queue: circular store addressed from the front slot
    logic [VALUE_W-1:0] slot_data [DEPTH];
    int unsigned        front_slot;
    int unsigned        fill;

    t_deq_result due_q[$];
    t_deq_result want;
    int          mismatches = 0;

    function automatic int unsigned slot_of(int unsigned offset);
        return (front_slot + offset) % DEPTH;
    endfunction

    function automatic void report_mismatch(string what, logic [VALUE_W-1:0] want_v,
                                            logic [VALUE_W-1:0] got_v);
        mismatches++;
        if (mismatches <= MAX_REPORT) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
        end
    endfunction

    // Apply one request to the shadow queue and return the result it yields
    function automatic t_deq_result apply_request(logic [MODE_W-1:0] op,
                                                  logic [VALUE_W-1:0] data);
        t_deq_result r;
        int unsigned pos;
        r.value_res = '0;
        r.status    = ST_OK;
        case (op)
            MODE_PUSH_BACK: begin
                if (fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot_data[slot_of(fill)] = data;
                    fill++;
                end
            end
            MODE_PUSH_FRONT: begin
                if (fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    front_slot = (front_slot + DEPTH - 1) % DEPTH;
                    slot_data[front_slot] = data;
                    fill++;
                end
            end
            MODE_POP_FRONT: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value_res = slot_data[front_slot];
                    front_slot  = (front_slot + 1) % DEPTH;
                    fill--;
                end
            end
            MODE_POP_BACK: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value_res = slot_data[slot_of(fill - 1)];
                    fill--;
                end
            end
            MODE_REMOVE: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // find the first match from the front
                    for (pos = 0; pos < fill; pos++) begin
                        if (slot_data[slot_of(pos)] == data) break;
                    end
                    if (pos == fill) begin
                        r.status = ST_NOMATCH;
                    end else begin
                        // close the gap, keep order
                        for (int unsigned j = pos; j + 1 < fill; j++) begin
                            slot_data[slot_of(j)] = slot_data[slot_of(j + 1)];
                        end
                        fill--;
                    end
                end
            end
            MODE_PEEK: begin
                if (fill == 0) r.status = ST_EMPTY;
                else r.value_res = slot_data[front_slot];
            end
            default: begin
            end
        endcase
        r.count = fill[COUNT_W-1:0];
        return r;
    endfunction

    // Compare results first, then predict the request accepted on the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_slot = 0;
            fill       = 0;
            due_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (due_q.size() == 0) begin
                    report_mismatch("result without request", '0, i_res.value_res);
                end else begin
                    want = due_q.pop_front();
                    if (i_res.value_res !== want.value_res)
                        report_mismatch("value_res", want.value_res, i_res.value_res);
                    if (i_res.status !== want.status)
                        report_mismatch("status", VALUE_W'(want.status), VALUE_W'(i_res.status));
                    if (i_res.count !== want.count)
                        report_mismatch("count", VALUE_W'(want.count), VALUE_W'(i_res.count));
                end
            end
            if (i_req.valid && i_req.ready) begin
                due_q.push_back(apply_request(i_req.mode, i_req.value));
            end
        end
        o_pending    <= due_q.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> tb/sv/tb_deque_with_remove_by_match.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_deque_with_remove_by_match - testbench of the double-ended queue
// Drives a directed set of requests covering empty, full, no-match and
// unused codes, then random requests with phases that fill and drain the
// queue, with random gaps on the request side and stalls on the result side.
// ---------------------------------------------------------------------------

module tb_deque_with_remove_by_match;
    import deq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int RAND_ITEMS  = 2000;
    localparam int TAIL_CYCLES = 2 * DEPTH + 8;

    // Codes the block treats as no operation
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    bit   steady = 1'b0;
    int   fail_count;
    int   pending;

    deq_req_if req_if ();
    deq_res_if res_if ();

    deque_with_remove_by_match u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    deq_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle cycles before a request: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Data: small values often so removals find matches
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 7);
            4: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // Present one request and hold it until accepted
    task automatic issue_request(logic [MODE_W-1:0] op, logic [VALUE_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode  <= op;
        req_if.value <= data;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Result side: random stalls, some long, none in steady stretches
    initial begin
        int stall;
        int r;
        stall = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            r = $urandom_range(0, 99);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else if (steady || r < 70) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= 1'b0;
                stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int                 r;
        int                 push_pct;
        logic [MODE_W-1:0]  op;
        push_pct = 50;
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.mode  <= '0;
        req_if.value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Empty queue: every read and removal must flag empty
        issue_request(MODE_PEEK, 32'h0);
        issue_request(MODE_POP_FRONT, 32'h0);
        issue_request(MODE_POP_BACK, 32'h0);
        issue_request(MODE_REMOVE, 32'h0);
        issue_request(MODE_SPARE_A, '1);
        issue_request(MODE_SPARE_B, 32'h0);

        // Fill from both ends with extremes and duplicates
        for (int k = 0; k < DEPTH; k++) begin
            issue_request(k[0] ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
                          (k == 1) ? '1 : (k == DEPTH - 1) ? 32'h8000_0001 : k % 5);
        end

        // Full queue, removals with and without a match, then reads
        issue_request(MODE_PUSH_BACK, 32'h5A5A_5A5A);
        issue_request(MODE_PUSH_FRONT, 32'hA5A5_A5A5);
        issue_request(MODE_REMOVE, 32'h1234_5678);
        issue_request(MODE_REMOVE, 32'd3);
        issue_request(MODE_REMOVE, 32'd0);
        issue_request(MODE_PEEK, 32'h0);
        issue_request(MODE_POP_BACK, 32'h0);
        issue_request(MODE_POP_FRONT, 32'h0);
        wait_drained();

        // Random requests in phases that lean toward filling or draining
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 64 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 2))
                    0: push_pct = 80;
                    1: push_pct = 50;
                    default: push_pct = 25;
                endcase
            end
            if (n == RAND_ITEMS / 2) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 2) begin
                op = $urandom_range(0, 1) ? MODE_SPARE_B : MODE_SPARE_A;
            end else if (r < push_pct) begin
                op = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 35) op = MODE_REMOVE;
                else if (r < 60) op = MODE_POP_FRONT;
                else if (r < 85) op = MODE_POP_BACK;
                else op = MODE_PEEK;
            end
            issue_request(op, pick_value());
        end

        // Drain, then let any stray result show up
        steady = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
